/* design/sitda_pkg.sv */
// ----------------------------------------------------------------------------
// sitda_pkg - shared constants, types and the conversion function
// Widths of the value and its decimal digit store, and the BCD conversion
// step used by the pipeline stages.
// ----------------------------------------------------------------------------
package sitda_pkg;

  // Width of the signed input value
  localparam int VALUE_W    = 32;
  // Decimal digits needed for a magnitude of up to 2^(VALUE_W-1)
  localparam int NUM_DIGITS = (VALUE_W * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  // Conversion stages, at most eight binary bits each
  localparam int DD_STAGES  = (VALUE_W + 7) / 8;
  localparam int STEP_BITS  = (VALUE_W + DD_STAGES - 1) / DD_STAGES;
  localparam int PAD_W      = DD_STAGES * STEP_BITS;
  localparam int CNT_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [PAD_W-1:0] bin_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    bcd_t bcd;
    bin_t bin;
  } dd_word_t;

  // Shift STEP_BITS binary bits (MSB first) into the BCD digits
  function automatic dd_word_t dd_chunk(input dd_word_t w);
    dd_word_t r;
    r = w;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (r.bcd[4*d +: 4] >= 4'd5) begin
          r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
        end
      end
      r.bcd = {r.bcd[BCD_W-2:0], r.bin[PAD_W-1]};
      r.bin = {r.bin[PAD_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* design/sitda_if.sv */
// ----------------------------------------------------------------------------
// sitda_if - channel interfaces
// Valid/ready channels for the integer input and the character output.
// ----------------------------------------------------------------------------
interface sitda_value_if
  import sitda_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

/* design/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii - signed integer to decimal ASCII text
// Converts each signed value into its decimal characters, one per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one signed VALUE_W-bit value per transfer (valid/ready).
//   out_chan : the decimal text of each value, most significant character
//              first, one character per transfer; is_last marks the final
//              character of a value. Negative values open with '-', zero
//              gives a single '0', no leading zeros are ever sent.
//   Pipeline : the first character of a value passes through the input
//              register, four BCD conversion stages of eight bits each, a
//              digit alignment stage and the serialiser.
//   Throughput: the serialiser sends one character per cycle while out_chan.ready
//              is high; a value has 1 to 11 characters at a 32-bit width. The
//              next value is loaded in the cycle its predecessor's last
//              character transfers, with no gap.
//   Reset    : synchronous, active low; clears every stage valid bit, the
//              block holds no other state.
//   Stall    : when out_chan.ready is low the current character holds; the
//              pipeline fills up behind it and in_chan.ready drops once all
//              stages are occupied. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  sitda_value_if.sink         in_chan,
  sitda_char_if.source        out_chan
);

  // Stage 0 is the input register; stages 1..DD_STAGES run the conversion
  logic     st_v_r   [0:DD_STAGES];
  logic     st_neg_r [0:DD_STAGES];
  dd_word_t st_w_r   [0:DD_STAGES];
  logic     st_rdy   [0:DD_STAGES];

  // Alignment stage
  logic     nm_v_r;
  logic     nm_neg_r;
  bcd_t     nm_bcd_r;
  cnt_t     nm_cnt_r;
  logic     nm_rdy;
  bcd_t     nm_bcd_nxt;
  cnt_t     nm_cnt_nxt;

  // Serialiser, which is also the output register
  logic     ser_v_r;
  logic     ser_neg_r;
  bcd_t     ser_bcd_r;
  cnt_t     ser_left_r;
  logic     ser_v_nxt;
  logic     ser_neg_nxt;
  bcd_t     ser_bcd_nxt;
  cnt_t     ser_left_nxt;
  logic     ser_load;
  logic     out_xfer;
  logic     out_last;

  logic [VALUE_W-1:0] in_mag;
  logic               in_neg;

  // ---------------------------------------------------------------------
  // Ready chain: a stage takes new data when empty or when it moves on
  // ---------------------------------------------------------------------
  assign st_rdy[DD_STAGES] = !st_v_r[DD_STAGES] || nm_rdy;
  for (genvar gr = 0; gr < DD_STAGES; gr++) begin : g_rdy
    assign st_rdy[gr] = !st_v_r[gr] || st_rdy[gr+1];
  end

  assign in_chan.ready = st_rdy[0];

  // ---------------------------------------------------------------------
  // Input stage: take the sign and form the unsigned magnitude. The most
  // negative value negates to itself, which read unsigned is exact.
  // ---------------------------------------------------------------------
  assign in_neg = in_chan.value[VALUE_W-1];
  assign in_mag = in_neg ? (~in_chan.value + 1'b1) : in_chan.value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r[0] <= 1'b0;
    end else if (st_rdy[0]) begin
      st_v_r[0] <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_rdy[0] && in_chan.valid) begin
      st_neg_r[0]   <= in_neg;
      st_w_r[0].bcd <= '0;
      st_w_r[0].bin <= PAD_W'(in_mag);
    end
  end

  // ---------------------------------------------------------------------
  // Conversion stages: shift-and-add-3, STEP_BITS binary bits per stage
  // ---------------------------------------------------------------------
  for (genvar gs = 1; gs <= DD_STAGES; gs++) begin : g_dd
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[gs] <= 1'b0;
      end else if (st_rdy[gs]) begin
        st_v_r[gs] <= st_v_r[gs-1];
      end
    end

    always_ff @(posedge clk) begin
      if (st_rdy[gs] && st_v_r[gs-1]) begin
        st_neg_r[gs] <= st_neg_r[gs-1];
        st_w_r[gs]   <= dd_chunk(st_w_r[gs-1]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Alignment: count significant digits (at least one, so zero gives '0')
  // and move the leading digit to the top of the word.
  // ---------------------------------------------------------------------
  always_comb begin
    nm_cnt_nxt = cnt_t'(1);
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (st_w_r[DD_STAGES].bcd[4*d +: 4] != 4'd0) begin
        nm_cnt_nxt = cnt_t'(d + 1);
      end
    end
    nm_bcd_nxt = st_w_r[DD_STAGES].bcd << (4 * (NUM_DIGITS - int'(nm_cnt_nxt)));
  end

  assign nm_rdy = !nm_v_r || ser_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_v_r <= 1'b0;
    end else if (nm_rdy) begin
      nm_v_r <= st_v_r[DD_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (nm_rdy && st_v_r[DD_STAGES]) begin
      nm_neg_r <= st_neg_r[DD_STAGES];
      nm_bcd_r <= nm_bcd_nxt;
      nm_cnt_r <= nm_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Serialiser: minus sign first if pending, then one digit per transfer
  // ---------------------------------------------------------------------
  assign out_last = !ser_neg_r && (ser_left_r == cnt_t'(1));
  assign out_xfer = ser_v_r && out_chan.ready;
  // Load the next value when empty or as the last character leaves
  assign ser_load = !ser_v_r || (out_xfer && out_last);

  always_comb begin
    ser_v_nxt    = ser_v_r;
    ser_neg_nxt  = ser_neg_r;
    ser_bcd_nxt  = ser_bcd_r;
    ser_left_nxt = ser_left_r;
    if (ser_load) begin
      ser_v_nxt    = nm_v_r;
      ser_neg_nxt  = nm_neg_r;
      ser_bcd_nxt  = nm_bcd_r;
      ser_left_nxt = nm_cnt_r;
    end else if (out_xfer) begin
      if (ser_neg_r) begin
        // Drop the sign, digits follow
        ser_neg_nxt = 1'b0;
      end else begin
        // Advance to the next digit
        ser_bcd_nxt  = ser_bcd_r << 4;
        ser_left_nxt = ser_left_r - cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
    end else begin
      ser_v_r <= ser_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ser_neg_r  <= ser_neg_nxt;
    ser_bcd_r  <= ser_bcd_nxt;
    ser_left_r <= ser_left_nxt;
  end

  assign out_chan.valid     = ser_v_r;
  assign out_chan.is_last   = out_last;
  assign out_chan.char_code = ser_neg_r ? CHAR_MINUS
                                        : (CHAR_ZERO | {4'd0, ser_bcd_r[BCD_W-1 -: 4]});

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ser_v_r |-> (ser_left_r != '0) && (ser_left_r <= cnt_t'(NUM_DIGITS)))
    else $error("serialiser digit count out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.char_code == CHAR_MINUS) |-> !out_chan.is_last)
    else $error("minus sign marked as last character");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !ser_neg_r) |->
      (out_chan.char_code >= CHAR_ZERO) && (out_chan.char_code <= CHAR_NINE))
    else $error("digit character outside 0..9");

  a_top_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (nm_v_r && nm_cnt_r != cnt_t'(1)) |-> (nm_bcd_r[BCD_W-1 -: 4] != 4'd0))
    else $error("leading zero after alignment");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !ser_v_r && !nm_v_r)
    else $error("valid bits not cleared by reset");

endmodule

/* verif/signed_int_to_decimal_ascii_test.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test - testbench for the integer to text block
// Sends signed 32-bit values into the block and checks every character that
// comes back against the decimal text predicted for the values transferred.
// A short table of hand-picked values comes first. Its fixed rows carry
// their text written out; the other rows are checked by the predictor.
// Four random phases follow, each with its own amount of sender idling and
// receiver stalling.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test
  import sitda_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 100;      // per phase, four phases
  localparam int DRAIN_CYCLES = 20;       // extra idle time after the final drain

  // One character as the output channel carries it
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } char_item_t;

  // One row of the directed table; an empty text means "ask the predictor"
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    string                     text;
  } directed_row_t;

  logic clk;
  logic rst_n;

  sitda_value_if in_chan ();
  sitda_char_if  out_chan ();

  // Characters still owed by the block, oldest first
  char_item_t pending_chars[$];

  int error_count;
  int cycle_count;
  int sender_idle_pct;
  int sink_stall_pct;

  directed_row_t directed_rows[];

  signed_int_to_decimal_ascii u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d characters outstanding", $realtime,
               pending_chars.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Queue the decimal text of a value: minus sign for negatives, then the
  // digits without leading zeros. The most negative value is negated as an
  // unsigned number so its magnitude comes out exact.
  function automatic void predict_decimal_text(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] magnitude;
    logic [7:0]         digit_chars[$];
    char_item_t         item;
    magnitude = v[VALUE_W-1] ? (~v + 1'b1) : v;
    do begin
      digit_chars.push_front(CHAR_ZERO + 8'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (v[VALUE_W-1]) begin
      item.char_code = CHAR_MINUS;
      item.is_last   = 1'b0;
      pending_chars.push_back(item);
    end
    foreach (digit_chars[i]) begin
      item.char_code = digit_chars[i];
      item.is_last   = (i == digit_chars.size() - 1);
      pending_chars.push_back(item);
    end
  endfunction

  // Queue text that was written out by hand
  function automatic void queue_written_text(input string text);
    char_item_t item;
    for (int i = 0; i < text.len(); i++) begin
      item.char_code = text[i];
      item.is_last   = (i == text.len() - 1);
      pending_chars.push_back(item);
    end
  endfunction

  // Watch both channels. Queue the text of each accepted value first, then
  // match each accepted character against the oldest one owed; the pipeline
  // registers between the two channels keep them apart anyway.
  int directed_index;
  logic use_written;
  string written_text;

  always @(posedge clk) begin
    char_item_t want;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      if (use_written && written_text.len() != 0) begin
        queue_written_text(written_text);
      end else begin
        predict_decimal_text(in_chan.value);
      end
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_chars.size() == 0) begin
        error_count++;
        $display("%0t: unexpected character: expected none, actual %0d last %0b",
                 $realtime, out_chan.char_code, out_chan.is_last);
      end else begin
        want = pending_chars.pop_front();
        if (out_chan.char_code !== want.char_code) begin
          error_count++;
          $display("%0t: char_code mismatch: expected %0d, actual %0d",
                   $realtime, want.char_code, out_chan.char_code);
        end
        if (out_chan.is_last !== want.is_last) begin
          error_count++;
          $display("%0t: is_last mismatch: expected %0b, actual %0b",
                   $realtime, want.is_last, out_chan.is_last);
        end
      end
    end
  end

  // Receiver: stall at the rate of the current phase
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Offer one value, idling first at the rate of the current phase, and
  // hold it until the transfer happens
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.value <= v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Drop valid and hold off until every owed character has come back
  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Random value, biased towards a spread of digit counts and the edges
  // around powers of ten
  function automatic logic signed [VALUE_W-1:0] random_value();
    logic signed [VALUE_W-1:0] v;
    int unsigned               power;
    if ($urandom_range(9) == 0) begin
      power = 1;
      repeat ($urandom_range(9)) power = power * 10;
      v = power + $urandom_range(2) - 1;
    end else begin
      v = $urandom >> $urandom_range(31);
    end
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  initial begin
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.value   <= '0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    use_written     = 1'b0;
    written_text    = "";

    directed_rows = '{
      '{32'sd0,            "0"},
      '{32'sd1,            "1"},
      '{-32'sd1,           "-1"},
      '{32'sh7FFF_FFFF,    "2147483647"},
      '{32'sh8000_0000,    "-2147483648"},
      '{32'sh8000_0001,    "-2147483647"},
      '{32'sd9,            ""},
      '{32'sd10,           ""},
      '{-32'sd10,          ""},
      '{32'sd99,           ""},
      '{32'sd100,          ""},
      '{-32'sd9,           ""},
      '{32'sd999999999,    ""},
      '{32'sd1000000000,   ""},
      '{-32'sd1000000000,  ""},
      '{-32'sd999999999,   ""},
      '{32'sd1999999999,   ""},
      '{32'sd123456789,    ""},
      '{-32'sd987654321,   ""},
      '{32'sh5555_5555,    ""},
      '{32'shAAAA_AAAA,    ""},
      '{32'sd7,            ""}
    };

    // Hold reset, then release it
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling. The written text is switched together
    // with the value so the monitor sees the pair at the transfer.
    use_written <= 1'b1;
    foreach (directed_rows[i]) begin
      written_text <= directed_rows[i].text;
      send_value(directed_rows[i].value);
    end
    use_written <= 1'b0;
    wait_for_drain();

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 52; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 52; end
        default: begin sender_idle_pct = 20; sink_stall_pct = 20; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        send_value(random_value());
      end
      // Let the block run dry once mid-run before the stall phase
      if (phase == 1) wait_for_drain();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
